// ----- hdl/block_average_missing_gate_unit_assert.svh -----
// Assertion shorthands used by the block's control module.
`ifndef BLOCK_AVERAGE_MISSING_GATE_UNIT_ASSERT_SVH
`define BLOCK_AVERAGE_MISSING_GATE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BAMG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BAMG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/bamg_pkg.sv -----
package bamg_pkg;

	localparam int MAX_RATE_DEF       = 64;
	localparam int MAX_PER_SECOND_DEF = 1024;

	localparam int SAMPLE_W = 32;
	localparam int RATE_W   = 7;
	localparam int PERSEC_W = 11;
	localparam int THR_W    = 7;
	localparam int CFG_W    = 11;
	localparam int IDX_W    = 2;

	localparam logic [IDX_W-1:0] REG_AVERAGE_RATE       = 2'd0;
	localparam logic [IDX_W-1:0] REG_SAMPLES_PER_SECOND = 2'd1;
	localparam logic [IDX_W-1:0] REG_MISS_THRESHOLD     = 2'd2;

	localparam logic [RATE_W-1:0]   AVERAGE_RATE_RST       = 7'd1;
	localparam logic [PERSEC_W-1:0] SAMPLES_PER_SECOND_RST = 11'd0;
	localparam logic [THR_W-1:0]    MISS_THRESHOLD_RST     = 7'd50;

	// -32767.0 in Q16.16
	localparam logic [SAMPLE_W-1:0] MISS_PATTERN = 32'h8001_0000;
	localparam logic [6:0]          PERCENT      = 7'd100;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic acc;
		logic close;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic miss;
		logic div_last;
	} status_t;

endpackage

// ----- hdl/bamg_ctrl.sv -----
`include "block_average_missing_gate_unit_assert.svh"

module bamg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bamg_pkg::status_t st,
	output bamg_pkg::cmd_t    cmd
);

	bamg_pkg::state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bamg_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bamg_pkg::S_IDLE: begin
				if (in_valid && st.last) state_d = bamg_pkg::S_CHECK;
			end
			bamg_pkg::S_CHECK: begin
				state_d = bamg_pkg::S_DIV;
			end
			bamg_pkg::S_DIV: begin
				if (st.miss || st.div_last) state_d = bamg_pkg::S_DONE;
			end
			bamg_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) state_d = bamg_pkg::S_IDLE;
			end
			default: state_d = bamg_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			bamg_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.acc  = in_valid;
			end
			bamg_pkg::S_CHECK: begin
				cmd.close = 1'b1;
			end
			bamg_pkg::S_DIV: begin
				// a gated group needs no quotient
				cmd.div_step = !st.miss;
			end
			bamg_pkg::S_DONE: begin
				cmd.load_out = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`BAMG_ASSERT_NEXT(a_close_follows_last, clk, arst_n, state_q == bamg_pkg::S_IDLE && in_valid && st.last, state_q == bamg_pkg::S_CHECK && !in_ready, "last word of a group did not close it")
	`BAMG_ASSERT_SAME(a_load_into_free_reg, clk, arst_n, cmd.load_out, !out_valid_q || out_ready, "result loaded over an untaken word")
	`BAMG_ASSERT_NEXT(a_gated_skips_divide, clk, arst_n, state_q == bamg_pkg::S_DIV && st.miss, state_q == bamg_pkg::S_DONE, "gated group entered the divider")
	`BAMG_ASSERT_NEXT(a_load_releases, clk, arst_n, cmd.load_out, out_valid && state_q == bamg_pkg::S_IDLE, "loaded result not presented")

endmodule

// ----- hdl/bamg_datapath.sv -----
module bamg_datapath #(
	parameter int MAX_RATE       = bamg_pkg::MAX_RATE_DEF,
	parameter int MAX_PER_SECOND = bamg_pkg::MAX_PER_SECOND_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bamg_pkg::IDX_W-1:0]          cfg_index,
	input  logic [bamg_pkg::CFG_W-1:0]          cfg_data,
	input  logic signed [bamg_pkg::SAMPLE_W-1:0] sample,
	input  bamg_pkg::cmd_t                      cmd,
	output bamg_pkg::status_t                   st,
	output logic signed [bamg_pkg::SAMPLE_W-1:0] average,
	output logic                                is_missing
);

	localparam int RW     = $clog2(MAX_RATE + 1);
	localparam int SW     = $clog2(MAX_PER_SECOND + 1);
	localparam int CNT_W  = RW + SW;
	localparam int SUM_W  = bamg_pkg::SAMPLE_W + CNT_W;
	localparam int P_W    = CNT_W + bamg_pkg::THR_W;
	localparam int DCNT_W = $clog2(SUM_W);

	logic [bamg_pkg::RATE_W-1:0]   avg_rate_q;
	logic [bamg_pkg::PERSEC_W-1:0] per_sec_q;
	logic [bamg_pkg::THR_W-1:0]    thr_q;

	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        seen_q, miss_q, g_q, good_q;
	logic [P_W-1:0]          m100_q, tg_q;
	logic [SUM_W-1:0]        quo_q;
	logic [CNT_W-1:0]        rem_q;
	logic                    neg_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic signed [bamg_pkg::SAMPLE_W-1:0] average_q;
	logic                    is_missing_q;

	logic [RW-1:0]    r_eff;
	logic [SW-1:0]    s_eff;
	logic [CNT_W-1:0] g_now, seen_inc;
	logic             is_miss_word;
	logic [SUM_W-1:0] sum_mag, quo_signed;
	logic [CNT_W:0]   trial;
	logic             q_bit;

	// clamp the rate and per-second settings into their legal ranges
	always_comb begin
		if (avg_rate_q == '0) begin
			r_eff = RW'(1);
		end else if (32'(avg_rate_q) > MAX_RATE) begin
			r_eff = RW'(MAX_RATE);
		end else begin
			r_eff = RW'(avg_rate_q);
		end
		if (per_sec_q == '0) begin
			s_eff = SW'(1);
		end else if (32'(per_sec_q) > MAX_PER_SECOND) begin
			s_eff = SW'(MAX_PER_SECOND);
		end else begin
			s_eff = SW'(per_sec_q);
		end
	end

	assign g_now        = CNT_W'(r_eff) * CNT_W'(s_eff);
	assign seen_inc     = seen_q + CNT_W'(1);
	assign is_miss_word = sample == bamg_pkg::MISS_PATTERN;
	assign sum_mag      = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
	assign trial        = {rem_q, quo_q[SUM_W-1]};
	assign q_bit        = trial >= {1'b0, good_q};
	assign quo_signed   = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;

	assign st.last     = seen_inc >= g_now;
	// floor(miss*100/G) >= thr is the same as miss*100 >= thr*G
	assign st.miss     = (m100_q >= tg_q) || (good_q == '0);
	assign st.div_last = dcnt_q == DCNT_W'(SUM_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_rate_q <= bamg_pkg::AVERAGE_RATE_RST;
			per_sec_q  <= bamg_pkg::SAMPLES_PER_SECOND_RST;
			thr_q      <= bamg_pkg::MISS_THRESHOLD_RST;
			sum_q      <= '0;
			seen_q     <= '0;
			miss_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bamg_pkg::REG_AVERAGE_RATE:
						avg_rate_q <= cfg_data[bamg_pkg::RATE_W-1:0];
					bamg_pkg::REG_SAMPLES_PER_SECOND:
						per_sec_q <= cfg_data[bamg_pkg::PERSEC_W-1:0];
					bamg_pkg::REG_MISS_THRESHOLD:
						thr_q <= cfg_data[bamg_pkg::THR_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.close) begin
				sum_q  <= '0;
				seen_q <= '0;
				miss_q <= '0;
			end else if (cmd.acc) begin
				seen_q <= seen_inc;
				if (is_miss_word) begin
					miss_q <= miss_q + CNT_W'(1);
				end else begin
					sum_q <= sum_q + {{(SUM_W - bamg_pkg::SAMPLE_W){sample[31]}}, sample};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			g_q <= g_now;
		end
		if (cmd.close) begin
			m100_q <= P_W'(miss_q) * P_W'(bamg_pkg::PERCENT);
			tg_q   <= P_W'(thr_q) * P_W'(g_q);
			good_q <= seen_q - miss_q;
			quo_q  <= sum_mag;
			neg_q  <= sum_q[SUM_W-1];
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			// one restoring step: shift in the next dividend bit
			rem_q  <= q_bit ? CNT_W'(trial - {1'b0, good_q}) : trial[CNT_W-1:0];
			quo_q  <= {quo_q[SUM_W-2:0], q_bit};
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
		if (cmd.load_out) begin
			if (st.miss) begin
				average_q    <= bamg_pkg::MISS_PATTERN;
				is_missing_q <= 1'b1;
			end else begin
				average_q    <= quo_signed[bamg_pkg::SAMPLE_W-1:0];
				is_missing_q <= 1'b0;
			end
		end
	end

	assign average    = average_q;
	assign is_missing = is_missing_q;

endmodule

// ----- hdl/block_average_missing_gate_unit.sv -----
// Boxcar average with decimation and a missing-value gate.
// Config: cfg_we writes cfg_data into register cfg_index (0 average_rate,
// 1 samples_per_second, 2 miss_threshold) at once; write only while idle.
// Input: sample words on in_valid/in_ready, Q16.16; 0x80010000 is missing.
// Output: one word (average, is_missing) on out_valid/out_ready per group.
// A word that does not close its group is accumulated as it is taken.
// The word that closes a group starts a close sequence: the gate
// products are formed, then either a gated result is chosen or a
// restoring divide of 32 + clog2(MAX_RATE+1) + clog2(MAX_PER_SECOND+1)
// steps runs, one quotient bit a cycle (50 at the defaults), then the
// output register is loaded once it is free. in_ready stays low for that
// sequence.
// The result is held in an output register, so the next group accumulates
// while it waits; a stalled receiver only holds the next close at its load.
// Reset clears the group sums and counts, drops any pending result and
// restores average_rate 1, samples_per_second 0, miss_threshold 50.
module block_average_missing_gate_unit #(
	parameter int MAX_RATE       = bamg_pkg::MAX_RATE_DEF,
	parameter int MAX_PER_SECOND = bamg_pkg::MAX_PER_SECOND_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bamg_pkg::IDX_W-1:0]           cfg_index,
	input  logic [bamg_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [bamg_pkg::SAMPLE_W-1:0] sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [bamg_pkg::SAMPLE_W-1:0] average,
	output logic                                 is_missing
);

	bamg_pkg::cmd_t    cmd;
	bamg_pkg::status_t st;

	bamg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	bamg_datapath #(
		.MAX_RATE       (MAX_RATE),
		.MAX_PER_SECOND (MAX_PER_SECOND)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (sample),
		.cmd        (cmd),
		.st         (st),
		.average    (average),
		.is_missing (is_missing)
	);

endmodule
